### rtl/vtbt_pkg.sv
// ----------------------------------------------------------------------------
// vtbt_pkg
// Shared types and codes for the volume table block translator.
// ----------------------------------------------------------------------------
`default_nettype none

package vtbt_pkg;

   localparam int VOL_IDX_W  = 4;
   localparam int BLOCK_W    = 16;
   localparam int START_CYL_W = 10;
   localparam int SEC_W      = 4;
   localparam int COUNT_W    = 16;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int CYL_W      = 13;
   localparam int SLOT_W     = 3;

   localparam int MAX_VOLUMES_DEF = 8;
   localparam int SEC_PER_CYL_DEF = 16;

   localparam logic OP_CREATE    = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNUSED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic                   op;
      logic [VOL_IDX_W-1:0]   vol_index;
      logic [BLOCK_W-1:0]     block_number;
      logic [START_CYL_W-1:0] start_cylinder;
      logic [SEC_W-1:0]       start_sector;
      logic [COUNT_W-1:0]     sector_count;
      logic [KIND_W-1:0]      vol_kind;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CYL_W-1:0]    cylinder;
      logic [SEC_W-1:0]    sector;
      logic [SLOT_W-1:0]   slot;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [START_CYL_W-1:0] cyl;
      logic [SEC_W-1:0]       sec;
      logic [COUNT_W-1:0]     count;
   } entry_type;

   typedef struct packed {
      logic                 idx_ok;
      entry_type            entry;
      logic                 free_found;
      logic [VOL_IDX_W-1:0] free_slot;
   } tbl_view_type;

endpackage

`default_nettype wire

### rtl/vtbt_table.sv
// ----------------------------------------------------------------------------
// vtbt_table
// Volume descriptor table: free-slot search, entry lookup and create write.
// ----------------------------------------------------------------------------
`default_nettype none

module vtbt_table
   import vtbt_pkg::*;
#(
   parameter int MAX_VOLUMES = MAX_VOLUMES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_type      req,
   input  wire logic         fire,
   output tbl_view_type      view
);

   localparam int IDX_W = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;

   entry_type table_ff [MAX_VOLUMES];
   entry_type new_entry;
   logic      wr_en;

   always_comb begin
      view.free_found = 1'b0;
      view.free_slot  = '0;
      for (int i = MAX_VOLUMES - 1; i >= 0; i--) begin
         if (table_ff[i].kind == KIND_NONE) begin
            view.free_found = 1'b1;
            view.free_slot  = VOL_IDX_W'(i);
         end
      end
      view.idx_ok = ({1'b0, req.vol_index} < (VOL_IDX_W + 1)'(MAX_VOLUMES));
      view.entry  = view.idx_ok ? table_ff[req.vol_index[IDX_W-1:0]] : '0;
   end

   always_comb begin
      new_entry.kind  = req.vol_kind;
      new_entry.cyl   = req.start_cylinder;
      new_entry.sec   = req.start_sector;
      new_entry.count = req.sector_count;
      wr_en = fire && (req.op == OP_CREATE) && view.free_found;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VOLUMES; i++) begin
            table_ff[i] <= '0;
         end
      end else if (wr_en) begin
         table_ff[view.free_slot[IDX_W-1:0]] <= new_entry;
      end
   end

endmodule

`default_nettype wire

### rtl/vtbt_xlate.sv
// ----------------------------------------------------------------------------
// vtbt_xlate
// Status checks and block to cylinder/sector arithmetic for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module vtbt_xlate
   import vtbt_pkg::*;
#(
   parameter int SECTORS_PER_CYLINDER = SEC_PER_CYL_DEF
) (
   input  wire req_type      req,
   input  wire tbl_view_type view,
   output rsp_type           rsp
);

   localparam int SUM_W   = BLOCK_W + 1;
   localparam int QUO_W   = SUM_W - 1;
   localparam int DIV_LOG = $clog2(SECTORS_PER_CYLINDER);
   localparam int SHIFT   = SUM_W + DIV_LOG;
   localparam int RCP_W   = SUM_W + 1;
   localparam int PROD_W  = SHIFT + QUO_W;
   localparam logic [63:0] RCP_WIDE =
      ((64'd1 << SHIFT) + 64'(SECTORS_PER_CYLINDER) - 64'd1) / 64'(SECTORS_PER_CYLINDER);
   localparam logic [RCP_W-1:0] RCP = RCP_WIDE[RCP_W-1:0];

   logic [SUM_W-1:0]  sum;
   logic [PROD_W-1:0] prod;
   logic [QUO_W-1:0]  quo;
   logic [SUM_W-1:0]  rem;
   logic [CYL_W-1:0]  cyl_sum;

   always_comb begin
      sum     = SUM_W'(view.entry.sec) + SUM_W'(req.block_number);
      prod    = PROD_W'(sum) * PROD_W'(RCP);
      quo     = prod[SHIFT +: QUO_W];
      rem     = sum - SUM_W'(SUM_W'(quo) * SUM_W'(SECTORS_PER_CYLINDER));
      cyl_sum = CYL_W'(view.entry.cyl) + quo[CYL_W-1:0];
   end

   always_comb begin
      rsp = '0;
      unique case (req.op)
         OP_CREATE: begin
            if (view.free_found) begin
               rsp.status = ST_OK;
               rsp.slot   = view.free_slot[SLOT_W-1:0];
            end else begin
               rsp.status = ST_FULL;
            end
         end
         OP_TRANSLATE: begin
            if (!view.idx_ok) begin
               rsp.status = ST_BAD_INDEX;
            end else if (view.entry.kind == KIND_NONE) begin
               rsp.status = ST_UNUSED;
            end else if (req.block_number >= view.entry.count) begin
               rsp.status = ST_RANGE;
            end else begin
               rsp.status   = ST_OK;
               rsp.cylinder = cyl_sum;
               rsp.sector   = rem[SEC_W-1:0];
            end
         end
         default: rsp = '0;
      endcase
   end

endmodule

`default_nettype wire

### rtl/volume_table_block_translate.sv
// ----------------------------------------------------------------------------
// volume_table_block_translate
// Volume table with create and block to cylinder/sector translation.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one create or translate transaction per valid/ready
//   handshake; rsp_* returns exactly one result per request, in order.
//   A request is held in an input register; the table lookup, free-slot
//   search and translation arithmetic run combinationally into the
//   result register, and a create updates the table on the edge that
//   loads the result, so the next request already sees the new entry.
//   Throughput: one transaction per cycle unless rsp_ready stalls it, set
//   by the single result register and the table read/write path.
//   Reset clears the valid flags of both pipeline registers and sets every
//   table entry to kind none with zero fields.
//   When rsp_ready is low the result holds; one more request can wait in
//   the input register, after which req_ready drops until the result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module volume_table_block_translate
   import vtbt_pkg::*;
#(
   parameter int MAX_VOLUMES          = MAX_VOLUMES_DEF,
   parameter int SECTORS_PER_CYLINDER = SEC_PER_CYL_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   req_type      req_ff;
   req_type      req_in;
   logic         req_vld_ff;
   logic         req_vld_in;
   rsp_type      rsp_ff;
   rsp_type      rsp_in;
   logic         rsp_vld_ff;
   logic         rsp_vld_in;
   logic         advance;
   tbl_view_type view;
   rsp_type      result;

   vtbt_table #(
      .MAX_VOLUMES (MAX_VOLUMES)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .req   (req_ff),
      .fire  (advance),
      .view  (view)
   );

   vtbt_xlate #(
      .SECTORS_PER_CYLINDER (SECTORS_PER_CYLINDER)
   ) u_xlate (
      .req  (req_ff),
      .view (view),
      .rsp  (result)
   );

   always_comb begin
      advance    = req_vld_ff && (!rsp_vld_ff || rsp_ready);
      req_ready  = !req_vld_ff || advance;
      req_vld_in = req_valid || (req_vld_ff && !advance);
      req_in     = (req_valid && req_ready) ? req_data : req_ff;
      rsp_vld_in = advance || (rsp_vld_ff && !rsp_ready);
      rsp_in     = advance ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_ready ? req_valid : req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // hold a request that cannot advance
   assert property (@(posedge clock) disable iff (reset)
      req_vld_ff && !advance |=> req_vld_ff && $stable(req_ff))
      else $error("pending request changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("advanced transaction produced no result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.status != ST_OK |->
         rsp_ff.cylinder == '0 && rsp_ff.sector == '0 && rsp_ff.slot == '0)
      else $error("error result carries nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_ff.status <= ST_FULL &&
         32'(rsp_ff.sector) < 32'(SECTORS_PER_CYLINDER))
      else $error("result status or sector out of range");

endmodule

`default_nettype wire

### verif/volume_table_checker.sv
// ----------------------------------------------------------------------------
// volume_table_checker
// Watches both channels of the volume table translator, keeps a shadow copy
// of the volume table, predicts the response of every accepted request and
// compares each accepted response field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module volume_table_checker
   import vtbt_pkg::*;
#(
   parameter int MAX_VOLUMES          = MAX_VOLUMES_DEF,
   parameter int SECTORS_PER_CYLINDER = SEC_PER_CYL_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      checked
);

   localparam int IDX_W = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;

   entry_type shadow_table [MAX_VOLUMES];
   rsp_type   pending_responses [$];
   int        fails;
   int        checks;

   function automatic rsp_type volume_response(input req_type r);
      rsp_type   res;
      entry_type e;
      int        sum;
      int        cyl;
      bit        found;
      res   = '0;
      found = 0;
      if (r.op == OP_CREATE) begin
         for (int i = 0; i < MAX_VOLUMES; i++) begin
            if (!found && shadow_table[i].kind == KIND_NONE) begin
               shadow_table[i].kind  = r.vol_kind;
               shadow_table[i].cyl   = r.start_cylinder;
               shadow_table[i].sec   = r.start_sector;
               shadow_table[i].count = r.sector_count;
               res.slot = i[SLOT_W-1:0];
               found    = 1;
            end
         end
         if (!found) begin
            res.status = ST_FULL;
         end
      end else if (int'(r.vol_index) >= MAX_VOLUMES) begin
         res.status = ST_BAD_INDEX;
      end else begin
         e = shadow_table[r.vol_index[IDX_W-1:0]];
         if (e.kind == KIND_NONE) begin
            res.status = ST_UNUSED;
         end else if (r.block_number >= e.count) begin
            res.status = ST_RANGE;
         end else begin
            sum          = int'(e.sec) + int'(r.block_number);
            cyl          = int'(e.cyl) + sum / SECTORS_PER_CYLINDER;
            res.status   = ST_OK;
            res.sector   = SEC_W'(sum % SECTORS_PER_CYLINDER);
            res.cylinder = CYL_W'(cyl);
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MAX_VOLUMES; i++) begin
            shadow_table[i] = '0;
         end
         pending_responses.delete();
         fails  = 0;
         checks = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_responses.size() == 0) begin
               if (fails < 10) begin
                  $display("unexpected response with nothing outstanding: %s",
                           $sformatf("status=%0d cyl=%0d sec=%0d slot=%0d",
                                     rsp_data.status, rsp_data.cylinder,
                                     rsp_data.sector, rsp_data.slot));
               end
               fails++;
            end else begin
               want = pending_responses.pop_front();
               checks++;
               if (rsp_data.status !== want.status ||
                   rsp_data.cylinder !== want.cylinder ||
                   rsp_data.sector !== want.sector || rsp_data.slot !== want.slot) begin
                  if (fails < 10) begin
                     $display("mismatch on response %0d:", checks);
                     $display("   expected status=%0d cyl=%0d sec=%0d slot=%0d",
                              want.status, want.cylinder, want.sector, want.slot);
                     $display("   got      status=%0d cyl=%0d sec=%0d slot=%0d",
                              rsp_data.status, rsp_data.cylinder, rsp_data.sector,
                              rsp_data.slot);
                  end
                  fails++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_responses.push_back(volume_response(req_data));
         end
      end
      fail_count <= fails;
      pending    <= pending_responses.size();
      checked    <= checks;
   end

endmodule

### verif/tb_volume_table_block_translate.sv
// ----------------------------------------------------------------------------
// tb_volume_table_block_translate
// Drives create and translate transactions into the volume table translator
// with random gaps and response back-pressure: a directed opening on the
// table edge cases, then random traffic. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_volume_table_block_translate
   import vtbt_pkg::*;
();

   localparam int NUM_VOLUMES  = MAX_VOLUMES_DEF;
   localparam int SEC_PER_CYL  = SEC_PER_CYL_DEF;
   localparam int RANDOM_ITEMS = 1400;

   localparam logic [KIND_W-1:0] KIND_BASE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ANNEX = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    steady_phase;
   int      fail_count;
   int      pending;
   int      checked;
   int      creates_sent;
   int      translates_sent;

   volume_table_block_translate #(
      .MAX_VOLUMES          (NUM_VOLUMES),
      .SECTORS_PER_CYLINDER (SEC_PER_CYL)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   volume_table_checker #(
      .MAX_VOLUMES          (NUM_VOLUMES),
      .SECTORS_PER_CYLINDER (SEC_PER_CYL)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic req_type random_bits();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type create_req(input logic [KIND_W-1:0] kind, input int cyl,
                                          input int sec, input int cnt);
      req_type r;
      r                = random_bits();
      r.op             = OP_CREATE;
      r.vol_kind       = kind;
      r.start_cylinder = START_CYL_W'(cyl);
      r.start_sector   = SEC_W'(sec);
      r.sector_count   = COUNT_W'(cnt);
      return r;
   endfunction

   function automatic req_type translate_req(input int idx, input int blk);
      req_type r;
      r              = random_bits();
      r.op           = OP_TRANSLATE;
      r.vol_index    = VOL_IDX_W'(idx);
      r.block_number = BLOCK_W'(blk);
      return r;
   endfunction

   // favor small and boundary values so translations land both in and out of range
   function automatic int sized_value();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5) begin
         return $urandom_range(65535);
      end else if (sel < 8) begin
         return $urandom_range(63);
      end else if (sel == 8) begin
         return 0;
      end
      return 65535;
   endfunction

   function automatic req_type random_req();
      logic [KIND_W-1:0] kind;
      int                idx;
      if ($urandom_range(99) < 6) begin
         case ($urandom_range(5))
            0, 1, 2: kind = KIND_NONE;
            3:       kind = KIND_BASE;
            4:       kind = KIND_ANNEX;
            default: kind = KIND_OTHER;
         endcase
         return create_req(kind, $urandom_range(1023), $urandom_range(15), sized_value());
      end
      if ($urandom_range(99) < 85) begin
         idx = $urandom_range(NUM_VOLUMES - 1);
      end else begin
         idx = $urandom_range(15, NUM_VOLUMES);
      end
      return translate_req(idx, sized_value());
   endfunction

   task automatic push_req(input req_type item);
      while (!steady_phase && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      if (item.op == OP_CREATE) begin
         creates_sent++;
      end else begin
         translates_sent++;
      end
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   initial begin : receiver
      int cycles;
      int hold;
      cycles = 0;
      hold   = 0;
      rsp_ready <= 1'b0;
      wait (reset === 1'b1);
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles == 400 || cycles == 1500) begin
            hold = 60;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (steady_phase) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 22);
         end
      end
   end

   initial begin : stimulus
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_data        <= '0;
      steady_phase    <= 1'b0;
      creates_sent    = 0;
      translates_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_req(translate_req(0, 0));
      push_req(translate_req(15, 65535));
      push_req(translate_req(NUM_VOLUMES, 0));
      push_req(create_req(KIND_BASE, 1023, 15, 65535));
      push_req(translate_req(0, 65534));
      push_req(translate_req(0, 65535));
      push_req(translate_req(0, 0));
      push_req(translate_req(0, 1));
      push_req(create_req(KIND_NONE, 100, 3, 50));
      push_req(translate_req(1, 0));
      push_req(create_req(KIND_ANNEX, 0, 0, 0));
      push_req(translate_req(1, 0));
      push_req(create_req(KIND_OTHER, 512, 7, 1));
      push_req(translate_req(2, 0));
      push_req(translate_req(2, 1));
      push_req(create_req(KIND_NONE, 1023, 15, 65535));
      push_req(translate_req(3, 0));
      push_req(create_req(KIND_BASE, 1, 9, 300));
      push_req(translate_req(3, 6));
      push_req(translate_req(3, 7));
      push_req(translate_req(3, 299));
      push_req(translate_req(3, 300));
      push_req(translate_req(4, 0));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady_phase <= (i >= 700 && i < 900);
         push_req(random_req());
      end
      req_valid    <= 1'b0;
      steady_phase <= 1'b0;

      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("covered %0d creates and %0d translates, %0d responses checked",
               creates_sent, translates_sent, checked);
      $display("table filled from empty through full, with gaps and back-pressure on both sides");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
